// File: hdl/mrr_pkg.sv
// Shared types, constants and the CRC-16/Modbus byte update for the read responder.
package mrr_pkg;

   localparam int MIN_FRAME_BYTES_DEFAULT = 8;
   localparam int CTX_DEPTH               = 1;

   localparam logic [15:0] CRC_INIT      = 16'hFFFF;
   localparam logic [15:0] CRC_POLY      = 16'hA001;
   localparam logic [7:0]  FUNC_READ     = 8'h03;
   localparam logic [7:0]  FUNC_ERROR    = 8'hFF;
   localparam logic [7:0]  ERR_COUNT_MAX = 8'hFF;
   localparam logic [3:0]  COUNT_MAX     = 4'd15;
   localparam logic [3:0]  POS_ADDRESS   = 4'd0;
   localparam logic [3:0]  POS_FUNCTION  = 4'd1;

   // Reply byte positions.
   localparam logic [2:0] REPLY_BYTE_CRC_LO = 3'd6;
   localparam logic [2:0] REPLY_BYTE_CRC_HI = 3'd7;

   typedef struct packed {
      logic [15:0] crc;
      logic [3:0]  count;
      logic [7:0]  address;
      logic [7:0]  function_code;
      logic [7:0]  error_count;
   } ctx_type;

   localparam ctx_type CTX_RESET = '{
      crc:           CRC_INIT,
      count:         4'd0,
      address:       8'd0,
      function_code: 8'd0,
      error_count:   8'd0
   };

   // First six reply bytes; byte 0 is sent first.
   typedef logic [5:0][7:0] msg_type;

   typedef struct packed {
      logic    valid;
      msg_type msg;
   } launch_type;

   function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'd0, b};
      for (int k = 0; k < 8; k++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

// File: hdl/mrr_if.sv
// Valid/ready channel interfaces for request bytes and reply bytes.
interface mrr_req_if;
   logic        valid;
   logic        ready;
   logic [7:0]  rx_byte;
   logic        frame_end;
   logic [15:0] reading;
   modport source (output valid, rx_byte, frame_end, reading, input ready);
   modport sink (input valid, rx_byte, frame_end, reading, output ready);
endinterface

interface mrr_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] tx_byte;
   logic       last_byte;
   modport source (output valid, tx_byte, last_byte, input ready);
   modport sink (input valid, tx_byte, last_byte, output ready);
endinterface

// File: hdl/modbus_rtu_read_responder_top.sv
// Top level of the Modbus RTU read responder.
//
// The req channel carries one received byte per beat, or a frame-end beat
// (frame_end high) that closes the frame and samples reading. The rsp channel
// carries reply bytes in transmit order; last_byte marks the eighth.
// csr_write_enable/csr_write_data set the station address (reset value 1).
//
// Data beats are taken one per cycle. The frame context (CRC, byte count,
// address, function, error count) lives in a one-entry RAM that is read when
// a beat is taken and written back when that beat's update completes; the
// written value is forwarded when beats follow each other directly.
// A frame end that calls for a reply starts the reply once the replier is
// free, and the eight reply bytes follow one per cycle while rsp is ready.
// A further frame end that needs a reply waits while the previous reply is
// still going out; data beats keep flowing in the meantime, and req stalls
// only then. A stalled receiver holds the current reply byte.
// Reset clears the context to its initial values and drops any reply in
// progress; no clearing pass is needed.
module modbus_rtu_read_responder_top #(
   parameter int MIN_FRAME_BYTES = mrr_pkg::MIN_FRAME_BYTES_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   mrr_req_if.sink    req,
   mrr_rsp_if.source  rsp,
   input  logic       csr_write_enable,
   input  logic [7:0] csr_write_data
);

   logic [7:0]          station_address_ff;
   logic                reply_free;
   mrr_pkg::launch_type launch;

   always_ff @(posedge clock) begin
      if (reset) begin
         station_address_ff <= 8'd1;
      end else if (csr_write_enable) begin
         station_address_ff <= csr_write_data;
      end
   end

   mrr_tracker #(
      .MIN_FRAME_BYTES (MIN_FRAME_BYTES)
   ) u_tracker (
      .clock           (clock),
      .reset           (reset),
      .req             (req),
      .station_address (station_address_ff),
      .reply_free      (reply_free),
      .launch          (launch)
   );

   mrr_replier u_replier (
      .clock      (clock),
      .reset      (reset),
      .launch     (launch),
      .reply_free (reply_free),
      .rsp        (rsp)
   );

endmodule

// File: hdl/mrr_ram.sv
// Generic simple dual-port synchronous RAM (one write port, one read port) with registered read data.
module mrr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hdl/mrr_tracker.sv
// Frame tracker: reads the frame context from RAM, updates it per beat and writes it back.
module mrr_tracker #(
   parameter int MIN_FRAME_BYTES = mrr_pkg::MIN_FRAME_BYTES_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   mrr_req_if.sink             req,
   input  logic [7:0]          station_address,
   input  logic                reply_free,
   output mrr_pkg::launch_type launch
);

   localparam int AW = (mrr_pkg::CTX_DEPTH > 1) ? $clog2(mrr_pkg::CTX_DEPTH) : 1;
   localparam logic [3:0] MIN_COUNT = 4'(MIN_FRAME_BYTES);

   logic            s1_valid_ff, s1_valid_in;
   logic [7:0]      s1_byte_ff;
   logic            s1_end_ff;
   logic [15:0]     s1_reading_ff;
   logic            fwd_valid_ff, fwd_valid_in;
   mrr_pkg::ctx_type fwd_ctx_ff;
   logic            mem_valid_ff;

   mrr_pkg::ctx_type ram_q, ctx_cur, ctx_next;
   logic            accept, s1_done;
   logic            long_frame, crc_bad, reply_go;
   logic [7:0]      err_next;
   mrr_pkg::msg_type msg;

   assign accept    = req.valid && req.ready;
   assign req.ready = !s1_valid_ff || s1_done;

   mrr_ram #(
      .WIDTH ($bits(mrr_pkg::ctx_type)),
      .DEPTH (mrr_pkg::CTX_DEPTH)
   ) u_ctx_ram (
      .clock   (clock),
      .wr_en   (s1_done),
      .wr_addr (AW'(0)),
      .wr_data (ctx_next),
      .rd_en   (accept),
      .rd_addr (AW'(0)),
      .rd_data (ram_q)
   );

   // A write at the same edge as the read returns stale data, so the written
   // context is forwarded to the next beat.
   always_comb begin
      if (fwd_valid_ff) begin
         ctx_cur = fwd_ctx_ff;
      end else if (mem_valid_ff) begin
         ctx_cur = ram_q;
      end else begin
         ctx_cur = mrr_pkg::CTX_RESET;
      end
   end

   always_comb begin
      long_frame = ctx_cur.count >= MIN_COUNT;
      crc_bad    = ctx_cur.crc != 16'd0;
      err_next   = ctx_cur.error_count;
      if (long_frame && crc_bad && ctx_cur.error_count != mrr_pkg::ERR_COUNT_MAX) begin
         err_next = ctx_cur.error_count + 8'd1;
      end
      reply_go = long_frame && (crc_bad || (ctx_cur.address == station_address
                                            && ctx_cur.function_code == mrr_pkg::FUNC_READ));
      if (crc_bad) begin
         msg = {err_next, 8'd0, 8'd0, 8'd0, mrr_pkg::FUNC_ERROR, station_address};
      end else begin
         msg = {s1_reading_ff[7:0], s1_reading_ff[15:8], 8'd0, 8'd0,
                mrr_pkg::FUNC_READ, ctx_cur.address};
      end

      ctx_next = ctx_cur;
      if (s1_end_ff) begin
         ctx_next             = mrr_pkg::CTX_RESET;
         ctx_next.error_count = err_next;
      end else begin
         ctx_next.crc = mrr_pkg::crc_update(ctx_cur.crc, s1_byte_ff);
         if (ctx_cur.count == mrr_pkg::POS_ADDRESS) begin
            ctx_next.address = s1_byte_ff;
         end
         if (ctx_cur.count == mrr_pkg::POS_FUNCTION) begin
            ctx_next.function_code = s1_byte_ff;
         end
         if (ctx_cur.count != mrr_pkg::COUNT_MAX) begin
            ctx_next.count = ctx_cur.count + 4'd1;
         end
      end
   end

   assign s1_done      = s1_valid_ff && (!s1_end_ff || !reply_go || reply_free);
   assign launch.valid = s1_valid_ff && s1_end_ff && reply_go && reply_free;
   assign launch.msg   = msg;

   always_comb begin
      s1_valid_in  = s1_valid_ff;
      fwd_valid_in = fwd_valid_ff;
      if (accept) begin
         s1_valid_in  = 1'b1;
         fwd_valid_in = s1_done;
      end else if (s1_done) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         fwd_valid_ff <= 1'b0;
         mem_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         fwd_valid_ff <= fwd_valid_in;
         if (s1_done) begin
            mem_valid_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_byte_ff    <= req.rx_byte;
         s1_end_ff     <= req.frame_end;
         s1_reading_ff <= req.reading;
         fwd_ctx_ff    <= ctx_next;
      end
   end

endmodule

// File: hdl/mrr_replier.sv
// Reply sequencer: sends six message bytes and their CRC, one beat per cycle while rsp is ready.
module mrr_replier (
   input  logic                clock,
   input  logic                reset,
   input  mrr_pkg::launch_type launch,
   output logic                reply_free,
   mrr_rsp_if.source           rsp
);

   logic             busy_ff;
   logic [2:0]       idx_ff;
   mrr_pkg::msg_type msg_ff;
   logic [15:0]      crc_ff;
   logic             take;
   logic [7:0]       cur_byte;

   assign take       = busy_ff && rsp.ready;
   assign reply_free = !busy_ff || (take && idx_ff == mrr_pkg::REPLY_BYTE_CRC_HI);

   always_comb begin
      case (idx_ff)
         3'd0:                       cur_byte = msg_ff[0];
         3'd1:                       cur_byte = msg_ff[1];
         3'd2:                       cur_byte = msg_ff[2];
         3'd3:                       cur_byte = msg_ff[3];
         3'd4:                       cur_byte = msg_ff[4];
         3'd5:                       cur_byte = msg_ff[5];
         mrr_pkg::REPLY_BYTE_CRC_LO: cur_byte = crc_ff[7:0];
         default:                    cur_byte = crc_ff[15:8];
      endcase
   end

   assign rsp.valid     = busy_ff;
   assign rsp.tx_byte   = cur_byte;
   assign rsp.last_byte = idx_ff == mrr_pkg::REPLY_BYTE_CRC_HI;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff  <= 3'd0;
      end else if (launch.valid) begin
         busy_ff <= 1'b1;
         idx_ff  <= 3'd0;
      end else if (take) begin
         idx_ff <= idx_ff + 3'd1;
         if (idx_ff == mrr_pkg::REPLY_BYTE_CRC_HI) begin
            busy_ff <= 1'b0;
         end
      end
   end

   // The CRC accumulates over the message bytes as they go out.
   always_ff @(posedge clock) begin
      if (launch.valid) begin
         msg_ff <= launch.msg;
         crc_ff <= mrr_pkg::CRC_INIT;
      end else if (take && idx_ff < mrr_pkg::REPLY_BYTE_CRC_LO) begin
         crc_ff <= mrr_pkg::crc_update(crc_ff, cur_byte);
      end
   end

endmodule

// File: tb/sv/testbench.sv
// Self-checking testbench for the Modbus RTU read responder: random frames, reply checking.
module testbench;
   import mrr_pkg::*;

   localparam int SETTLE_CYCLES  = 6;
   localparam int HOLDOFF_CYCLES = 300;
   localparam int DRAIN_LIMIT    = 5000;
   localparam int RUN_LIMIT      = 1000000;

   typedef logic [7:0] byte_q_type[$];

   typedef struct packed {
      logic [7:0] tx_byte;
      logic       last_byte;
   } reply_beat_type;

   typedef enum int {
      FRAME_READ,
      FRAME_OTHER_ADDR,
      FRAME_OTHER_FUNC,
      FRAME_BAD_CRC,
      FRAME_SHORT,
      FRAME_LONG,
      FRAME_NOISE
   } frame_kind_type;

   typedef enum int {
      READY_ALWAYS,
      READY_COIN,
      READY_SPARSE,
      READY_PERIODIC
   } stall_mode_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       csr_write_enable = 1'b0;
   logic [7:0] csr_write_data = 8'h00;

   mrr_req_if req_ch();
   mrr_rsp_if rsp_ch();

   modbus_rtu_read_responder_top dut (
      .clock            (clock),
      .reset            (reset),
      .req              (req_ch),
      .rsp              (rsp_ch),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   // Predicted slave state.
   logic [7:0]  station_addr = 8'd1;
   logic [15:0] frame_crc    = CRC_INIT;
   logic [3:0]  frame_len    = 4'd0;
   logic [7:0]  frame_addr   = 8'd0;
   logic [7:0]  frame_func   = 8'd0;
   logic [7:0]  err_count    = 8'd0;

   reply_beat_type pending_reply_beats[$];

   int fail_count = 0;
   int burst_left = 0;
   bit sender_idle_enable = 1'b1;
   bit holdoff_request = 1'b0;

   initial begin
      forever #1 clock = ~clock;
   end

   initial begin
      #RUN_LIMIT;
      $display("Test completed with failures");
      $finish;
   end

   task automatic report_mismatch(input string what, input logic [7:0] got,
                                  input logic [7:0] want);
      $display("MISMATCH at %0t: %s, got %02h, expected %02h", $time, what, got, want);
      fail_count++;
   endtask

   // Bitwise form of the reflected CRC-16: each data bit is folded into the LSB feedback.
   function automatic logic [15:0] modbus_crc_byte(input logic [15:0] acc,
                                                   input logic [7:0] data);
      logic [15:0] r;
      logic        fb;
      r = acc;
      for (int i = 0; i < 8; i++) begin
         fb = r[0] ^ data[i];
         r  = {1'b0, r[15:1]} ^ (fb ? CRC_POLY : 16'h0000);
      end
      return r;
   endfunction

   function automatic logic [15:0] frame_crc_of(input byte_q_type q);
      logic [15:0] c;
      c = CRC_INIT;
      foreach (q[i]) c = modbus_crc_byte(c, q[i]);
      return c;
   endfunction

   function automatic void predict_reply(input logic [7:0] data, input logic closes,
                                         input logic [15:0] value);
      logic [7:0]  msg [8];
      logic [15:0] c;
      bit          answer;
      answer = 1'b0;
      foreach (msg[k]) msg[k] = 8'h00;
      if (!closes) begin
         frame_crc = modbus_crc_byte(frame_crc, data);
         if (frame_len == POS_ADDRESS) begin
            frame_addr = data;
         end else if (frame_len == POS_FUNCTION) begin
            frame_func = data;
         end
         if (frame_len != COUNT_MAX) frame_len++;
      end else begin
         if (int'(frame_len) >= MIN_FRAME_BYTES_DEFAULT) begin
            if (frame_crc != 16'h0000) begin
               if (err_count != ERR_COUNT_MAX) err_count++;
               msg[0] = station_addr;
               msg[1] = FUNC_ERROR;
               msg[5] = err_count;
               answer = 1'b1;
            end else if (frame_addr == station_addr && frame_func == FUNC_READ) begin
               msg[0] = frame_addr;
               msg[1] = FUNC_READ;
               msg[4] = value[15:8];
               msg[5] = value[7:0];
               answer = 1'b1;
            end
         end
         if (answer) begin
            c = CRC_INIT;
            for (int k = 0; k < int'(REPLY_BYTE_CRC_LO); k++) c = modbus_crc_byte(c, msg[k]);
            msg[REPLY_BYTE_CRC_LO] = c[7:0];
            msg[REPLY_BYTE_CRC_HI] = c[15:8];
            for (int k = 0; k < 8; k++) begin
               pending_reply_beats.push_back('{tx_byte: msg[k],
                                               last_byte: (k == int'(REPLY_BYTE_CRC_HI))});
            end
         end
         frame_crc  = CRC_INIT;
         frame_len  = 4'd0;
         frame_addr = 8'd0;
         frame_func = 8'd0;
      end
   endfunction

   // Called at a falling edge; returns at a falling edge with valid low.
   task automatic send_beat(input logic [7:0] data, input logic closes,
                            input logic [15:0] value);
      if (sender_idle_enable && burst_left == 0) begin
         repeat ($urandom_range(1, 6)) @(negedge clock);
         burst_left = $urandom_range(1, 16);
      end
      if (burst_left > 0) burst_left--;
      req_ch.valid     = 1'b1;
      req_ch.rx_byte   = data;
      req_ch.frame_end = closes;
      req_ch.reading   = value;
      @(posedge clock);
      while (req_ch.ready !== 1'b1) @(posedge clock);
      predict_reply(data, closes, value);
      @(negedge clock);
      req_ch.valid = 1'b0;
   endtask

   task automatic send_frame(input byte_q_type q, input logic [15:0] value);
      foreach (q[i]) send_beat(q[i], 1'b0, 16'($urandom));
      send_beat(8'($urandom), 1'b1, value);
   endtask

   task automatic build_frame(input frame_kind_type kind, output byte_q_type q);
      logic [7:0]  a;
      logic [7:0]  f;
      logic [15:0] c;
      int          n;
      int          idx;
      bit          seal;
      q    = {};
      a    = station_addr;
      f    = FUNC_READ;
      n    = 4;
      seal = 1'b1;
      case (kind)
         FRAME_OTHER_ADDR: begin
            do a = 8'($urandom); while (a == station_addr);
         end
         FRAME_OTHER_FUNC: begin
            do f = 8'($urandom); while (f == FUNC_READ);
         end
         FRAME_BAD_CRC: begin
            if ($urandom_range(0, 1) == 0) a = 8'($urandom);
         end
         FRAME_SHORT: begin
            n    = $urandom_range(0, 3);
            seal = ($urandom_range(0, 1) == 1);
         end
         FRAME_LONG: begin
            n = $urandom_range(5, 18);
            if ($urandom_range(0, 2) == 0) a = 8'($urandom);
            if ($urandom_range(0, 3) == 0) f = 8'($urandom);
         end
         FRAME_NOISE: begin
            n    = $urandom_range(6, 10);
            a    = 8'($urandom);
            f    = 8'($urandom);
            seal = 1'b0;
         end
         default: ;
      endcase
      q.push_back(a);
      q.push_back(f);
      repeat (n) q.push_back(8'($urandom));
      if (seal) begin
         c = frame_crc_of(q);
         q.push_back(c[7:0]);
         q.push_back(c[15:8]);
      end
      // A single flipped bit always leaves a nonzero CRC residue.
      if (kind == FRAME_BAD_CRC) begin
         idx    = $urandom_range(0, q.size() - 1);
         q[idx] = q[idx] ^ (8'h01 << $urandom_range(0, 7));
      end
      if (kind == FRAME_SHORT && $urandom_range(0, 3) == 0) begin
         n = $urandom_range(0, 1);
         while (q.size() > n) void'(q.pop_back());
      end
   endtask

   task automatic random_frames(input int item_count);
      int             sent;
      int             pick;
      frame_kind_type kind;
      byte_q_type     q;
      sent = 0;
      while (sent < item_count) begin
         pick = $urandom_range(0, 99);
         if (pick < 40)      kind = FRAME_READ;
         else if (pick < 52) kind = FRAME_BAD_CRC;
         else if (pick < 60) kind = FRAME_OTHER_ADDR;
         else if (pick < 68) kind = FRAME_OTHER_FUNC;
         else if (pick < 78) kind = FRAME_SHORT;
         else if (pick < 90) kind = FRAME_LONG;
         else                kind = FRAME_NOISE;
         build_frame(kind, q);
         send_frame(q, 16'($urandom));
         sent += q.size() + 1;
      end
   endtask

   task automatic wait_idle();
      while (pending_reply_beats.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic set_station(input logic [7:0] addr);
      wait_idle();
      csr_write_enable = 1'b1;
      csr_write_data   = addr;
      @(negedge clock);
      csr_write_enable = 1'b0;
      station_addr     = addr;
   endtask

   task automatic test_read_at_reset_address();
      byte_q_type  q;
      logic [15:0] c;
      q = '{station_addr, FUNC_READ, 8'h00, 8'h00, 8'h00, 8'h01};
      c = frame_crc_of(q);
      q.push_back(c[7:0]);
      q.push_back(c[15:8]);
      send_frame(q, 16'hFFFF);
   endtask

   task automatic test_short_frames();
      byte_q_type  q;
      logic [15:0] c;
      send_beat(8'hFF, 1'b1, 16'($urandom));
      // Seven bytes with a correct CRC are still one byte too few.
      q = '{station_addr, FUNC_READ, 8'h00, 8'h00, 8'h01};
      c = frame_crc_of(q);
      q.push_back(c[7:0]);
      q.push_back(c[15:8]);
      send_frame(q, 16'($urandom));
   endtask

   task automatic test_crc_error();
      byte_q_type  q;
      logic [15:0] c;
      // The error reply goes out even though the address is not ours.
      q = '{8'hFF, FUNC_READ, 8'h00, 8'h00, 8'h00, 8'h01};
      c = frame_crc_of(q);
      q.push_back(c[7:0]);
      q.push_back(~c[15:8]);
      send_frame(q, 16'h0000);
   endtask

   task automatic test_station_extremes();
      set_station(8'h00);
      random_frames(25);
      set_station(8'hFF);
      random_frames(25);
   endtask

   task automatic test_random_traffic();
      repeat (4) begin
         set_station(8'($urandom));
         sender_idle_enable = ($urandom_range(0, 3) != 0);
         random_frames(25);
      end
      sender_idle_enable = 1'b1;
   endtask

   task automatic test_input_backpressure();
      byte_q_type q;
      wait_idle();
      sender_idle_enable = 1'b0;
      holdoff_request    = 1'b1;
      repeat (4) begin
         build_frame(FRAME_READ, q);
         send_frame(q, 16'($urandom));
      end
      sender_idle_enable = 1'b1;
   endtask

   task automatic test_crc_error_run();
      byte_q_type q;
      set_station(8'($urandom));
      sender_idle_enable = 1'b0;
      repeat (3) begin
         build_frame(FRAME_BAD_CRC, q);
         send_frame(q, 16'($urandom));
      end
      sender_idle_enable = 1'b1;
   endtask

   // Receiver side: a stall pattern that is drawn anew at random.
   initial begin
      stall_mode_type mode;
      int             mode_left;
      int             phase;
      mode         = READY_ALWAYS;
      mode_left    = 0;
      phase        = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (holdoff_request) begin
            rsp_ch.ready = 1'b0;
            repeat (HOLDOFF_CYCLES) @(negedge clock);
            holdoff_request = 1'b0;
         end
         if (mode_left == 0) begin
            mode      = stall_mode_type'($urandom_range(0, 3));
            mode_left = $urandom_range(20, 120);
         end
         mode_left--;
         phase++;
         case (mode)
            READY_ALWAYS:   rsp_ch.ready = 1'b1;
            READY_COIN:     rsp_ch.ready = ($urandom_range(0, 1) == 1);
            READY_SPARSE:   rsp_ch.ready = ($urandom_range(0, 3) == 0);
            default:        rsp_ch.ready = (phase % 5 != 0);
         endcase
      end
   end

   always @(posedge clock) begin
      reply_beat_type want;
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         if (pending_reply_beats.size() == 0) begin
            report_mismatch("reply beat with none expected", rsp_ch.tx_byte, 8'h00);
         end else begin
            want = pending_reply_beats.pop_front();
            if (rsp_ch.tx_byte !== want.tx_byte) begin
               report_mismatch("tx_byte", rsp_ch.tx_byte, want.tx_byte);
            end
            if (rsp_ch.last_byte !== want.last_byte) begin
               report_mismatch("last_byte", {7'd0, rsp_ch.last_byte}, {7'd0, want.last_byte});
            end
         end
      end
   end

   initial begin
      int drain;
      req_ch.valid     = 1'b0;
      req_ch.rx_byte   = 8'h00;
      req_ch.frame_end = 1'b0;
      req_ch.reading   = 16'h0000;
      repeat (11) @(negedge clock);
      reset = 1'b0;

      test_read_at_reset_address();
      test_short_frames();
      test_crc_error();
      test_station_extremes();
      test_random_traffic();
      test_input_backpressure();
      test_crc_error_run();

      drain = 0;
      while (pending_reply_beats.size() != 0 && drain < DRAIN_LIMIT) begin
         @(posedge clock);
         drain++;
      end
      repeat (20) @(posedge clock);
      if (pending_reply_beats.size() != 0) begin
         report_mismatch("reply beat never sent", 8'h00, pending_reply_beats[0].tx_byte);
      end
      if (fail_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
